// ===== rtl/skyfe_pkg.sv =====
// Shared types, constants and the CORDIC angle table for the fisheye sky lookup.
package skyfe_pkg;

	// Datapath widths: vectoring lanes, angles (Q30 radians), rotation lanes
	localparam int VW = 36;
	localparam int AW = 34;
	localparam int RW = 30;

	// Request queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPW    = 2;

	// Configuration register indexes
	localparam logic [1:0] REG_TEXTURE    = 2'd0;
	localparam logic [1:0] REG_ROWS       = 2'd1;
	localparam logic [1:0] REG_COLS       = 2'd2;
	localparam logic [1:0] REG_BACKGROUND = 2'd3;

	// Fixed-point constants, Q30
	localparam logic signed [AW-1:0] HALF_PI     = 34'sd1686629713;
	localparam logic signed [32:0]   KGAIN       = 33'sd1768195363;
	localparam logic signed [32:0]   INVK        = 33'sd652032874;
	localparam logic signed [32:0]   TWO_OVER_PI = 33'sd683565276;
	localparam logic [30:0]          ONE_Q30     = 31'd1073741824;

	// One classified request as it sits in the queue
	typedef struct packed {
		logic                 bg;   // background color applies
		logic                 ctr;  // x and y both zero: center pixel
		logic signed [VW-1:0] gx;   // pre-rotated x, always >= 0
		logic signed [VW-1:0] gy;   // pre-rotated y
		logic signed [AW-1:0] az;   // azimuth of the pre-rotation
		logic signed [31:0]   z;    // scaled z component
	} item_t;

	// Micro-rotation angle atan(2^-i) in Q30
	function automatic logic signed [AW-1:0] step_angle(input int i);
		logic signed [AW-1:0] r;
		case (i)
			0: r = 34'sh03243F6A8;
			1: r = 34'sh01DAC6705;
			2: r = 34'sh00FADBAFC;
			3: r = 34'sh007F56EA6;
			4: r = 34'sh003FEAB76;
			5: r = 34'sh001FFD55B;
			6: r = 34'sh000FFFAAA;
			7: r = 34'sh0007FFF55;
			8: r = 34'sh0003FFFEA;
			9: r = 34'sh0001FFFFD;
			default: r = (i <= 30) ? (34'sd1 <<< (30 - i)) : '0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/skyfe_front.sv =====
// Front end: scales the direction, flags background and center requests, pre-rotates into x >= 0.
module skyfe_front #(
	parameter int DIR_BITS = 16
) (
	input  logic signed [DIR_BITS-1:0] dir_x,
	input  logic signed [DIR_BITS-1:0] dir_y,
	input  logic signed [DIR_BITS-1:0] dir_z,
	input  logic                       texture_present,
	output skyfe_pkg::item_t           item
);

	logic signed [31:0]               xs, ys, zs;
	logic signed [skyfe_pkg::VW-1:0]  xw, yw;

	assign xs = 32'(dir_x) <<< (32 - DIR_BITS);
	assign ys = 32'(dir_y) <<< (32 - DIR_BITS);
	assign zs = 32'(dir_z) <<< (32 - DIR_BITS);
	assign xw = skyfe_pkg::VW'(xs);
	assign yw = skyfe_pkg::VW'(ys);

	always_comb begin
		item.bg  = !texture_present || dir_z[DIR_BITS-1];
		item.ctr = (dir_x == '0) && (dir_y == '0);
		item.z   = zs;
		if (xw < 0) begin
			if (yw >= 0) begin
				item.gx = yw;
				item.gy = -xw;
				item.az = skyfe_pkg::HALF_PI;
			end else begin
				item.gx = -yw;
				item.gy = xw;
				item.az = -skyfe_pkg::HALF_PI;
			end
		end else begin
			item.gx = xw;
			item.gy = yw;
			item.az = '0;
		end
	end

endmodule

// ===== rtl/skyfe_queue.sv =====
// Short request queue decoupling the front end from the CORDIC back end.
module skyfe_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  skyfe_pkg::item_t push_item,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output skyfe_pkg::item_t head_item
);

	skyfe_pkg::item_t              mem_q [skyfe_pkg::QDEPTH];
	logic [skyfe_pkg::QPW-1:0]     wptr_q, rptr_q;
	logic [skyfe_pkg::QPW:0]       count_q;

	assign full       = (count_q == (skyfe_pkg::QPW+1)'(skyfe_pkg::QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop)  rptr_q <= rptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/skyfe_back.sv =====
// Back end: azimuth and zenith vectoring, scaling, offset rotation and pixel clamp, fully pipelined.
module skyfe_back #(
	parameter int CORDIC_STEPS   = 16,
	parameter int MAX_IMAGE_SIDE = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  skyfe_pkg::item_t head_item,
	output logic             pop,
	input  logic [12:0]      image_rows,
	input  logic [12:0]      image_cols,
	input  logic [23:0]      background_rgb,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             use_background,
	output logic [11:0]      pixel_row,
	output logic [11:0]      pixel_col,
	output logic [23:0]      color_out
);

	localparam int N  = CORDIC_STEPS;
	localparam int L  = 3 * N + 6;
	localparam int VW = skyfe_pkg::VW;
	localparam int AW = skyfe_pkg::AW;
	localparam int RW = skyfe_pkg::RW;

	logic adv;
	logic vs_q [L];
	logic [1:0] fl_s [L];   // {bg, ctr}

	// Image geometry from the live registers
	logic [12:0] rows_l, cols_l;
	logic [11:0] crow, ccol, rad;

	assign rows_l = (32'(image_rows) > MAX_IMAGE_SIDE) ? 13'(MAX_IMAGE_SIDE) : image_rows;
	assign cols_l = (32'(image_cols) > MAX_IMAGE_SIDE) ? 13'(MAX_IMAGE_SIDE) : image_cols;
	assign crow   = rows_l[12:1];
	assign ccol   = cols_l[12:1];
	assign rad    = (crow < ccol) ? crow : ccol;

	assign adv = !out_valid || !out_stall;
	assign pop = adv && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < L; k++) vs_q[k] <= 1'b0;
		end else if (adv) begin
			vs_q[0] <= head_valid;
			for (int k = 1; k < L; k++) vs_q[k] <= vs_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fl_s[0] <= {head_item.bg, head_item.ctr};
			for (int k = 1; k < L; k++) fl_s[k] <= fl_s[k-1];
		end
	end

	// Azimuth vectoring, with z*K riding alongside
	logic signed [VW-1:0] ga_s [N+1];
	logic signed [VW-1:0] ya_s [N+1];
	logic signed [AW-1:0] aa_s [N+1];
	logic signed [VW-1:0] za_s [N+1];
	logic signed [63:0]   zprod;

	assign zprod = head_item.z * skyfe_pkg::KGAIN;

	always_ff @(posedge clk) begin
		if (adv) begin
			ga_s[0] <= head_item.gx;
			ya_s[0] <= head_item.gy;
			aa_s[0] <= head_item.az;
			za_s[0] <= $signed(zprod[63:30]);
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_azim
		always_ff @(posedge clk) begin
			if (adv) begin
				za_s[i+1] <= za_s[i];
				if (ya_s[i] > 0) begin
					ga_s[i+1] <= ga_s[i] + (ya_s[i] >>> i);
					ya_s[i+1] <= ya_s[i] - (ga_s[i] >>> i);
					aa_s[i+1] <= aa_s[i] + skyfe_pkg::step_angle(i);
				end else begin
					ga_s[i+1] <= ga_s[i] - (ya_s[i] >>> i);
					ya_s[i+1] <= ya_s[i] + (ga_s[i] >>> i);
					aa_s[i+1] <= aa_s[i] - skyfe_pkg::step_angle(i);
				end
			end
		end
	end

	// Zenith vectoring on (z*K, gained radius)
	logic signed [VW-1:0] xb_s [N+1];
	logic signed [VW-1:0] yb_s [N+1];
	logic signed [AW-1:0] tb_s [N+1];
	logic signed [AW-1:0] zb_s [N+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			xb_s[0] <= za_s[N];
			yb_s[0] <= ga_s[N];
			tb_s[0] <= '0;
			zb_s[0] <= aa_s[N];
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_zen
		always_ff @(posedge clk) begin
			if (adv) begin
				zb_s[i+1] <= zb_s[i];
				if (yb_s[i] > 0) begin
					xb_s[i+1] <= xb_s[i] + (yb_s[i] >>> i);
					yb_s[i+1] <= yb_s[i] - (xb_s[i] >>> i);
					tb_s[i+1] <= tb_s[i] + skyfe_pkg::step_angle(i);
				end else begin
					xb_s[i+1] <= xb_s[i] - (yb_s[i] >>> i);
					yb_s[i+1] <= yb_s[i] + (xb_s[i] >>> i);
					tb_s[i+1] <= tb_s[i] - skyfe_pkg::step_angle(i);
				end
			end
		end
	end

	// Zenith angle to fraction of the horizon, then to radius in Q16
	logic signed [31:0]   zd;
	logic signed [63:0]   fprod;
	logic [30:0]          f_s1, f_cl;
	logic signed [AW-1:0] az_s1, az_s2;
	logic [42:0]          pprod;
	logic [28:0]          p_s2;

	always_comb begin
		if (tb_s[N] < 0) zd = '0;
		else if (tb_s[N] > skyfe_pkg::HALF_PI) zd = 32'(skyfe_pkg::HALF_PI);
		else zd = 32'(tb_s[N]);
	end

	assign fprod = zd * skyfe_pkg::TWO_OVER_PI;
	assign f_cl  = (f_s1 > skyfe_pkg::ONE_Q30) ? skyfe_pkg::ONE_Q30 : f_s1;
	assign pprod = 43'(f_cl) * 43'(rad);

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s1  <= fprod[60:30];
			az_s1 <= zb_s[N];
			p_s2  <= pprod[42:14];
			az_s2 <= az_s1;
		end
	end

	// Offset rotation of (p, 0) by the azimuth
	logic signed [RW-1:0] cx_s [N+1];
	logic signed [RW-1:0] cy_s [N+1];
	logic signed [AW-1:0] rs_s [N+1];
	logic signed [RW-1:0] pw;

	assign pw = $signed({1'b0, p_s2});

	always_ff @(posedge clk) begin
		if (adv) begin
			if (az_s2 > skyfe_pkg::HALF_PI) begin
				cx_s[0] <= '0;
				cy_s[0] <= pw;
				rs_s[0] <= az_s2 - skyfe_pkg::HALF_PI;
			end else if (az_s2 < -skyfe_pkg::HALF_PI) begin
				cx_s[0] <= '0;
				cy_s[0] <= -pw;
				rs_s[0] <= az_s2 + skyfe_pkg::HALF_PI;
			end else begin
				cx_s[0] <= pw;
				cy_s[0] <= '0;
				rs_s[0] <= az_s2;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (adv) begin
				if (rs_s[i] >= 0) begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					rs_s[i+1] <= rs_s[i] - skyfe_pkg::step_angle(i);
				end else begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					rs_s[i+1] <= rs_s[i] + skyfe_pkg::step_angle(i);
				end
			end
		end
	end

	// Remove CORDIC gain
	logic signed [63:0]   vxp, vyp;
	logic signed [RW-1:0] vx_s3, vy_s3;

	assign vxp = cx_s[N] * skyfe_pkg::INVK;
	assign vyp = cy_s[N] * skyfe_pkg::INVK;

	always_ff @(posedge clk) begin
		if (adv) begin
			vx_s3 <= $signed(vxp[59:30]);
			vy_s3 <= $signed(vyp[59:30]);
		end
	end

	// Whole pixels (toward zero), center offset and clamp to the image
	logic signed [RW-1:0] tx, ty;
	logic signed [15:0]   colv, rowv;
	logic [11:0]          row_c, col_c;
	logic [1:0]           fl_last;

	assign tx = vx_s3[RW-1] ? -((-vx_s3) >>> 16) : (vx_s3 >>> 16);
	assign ty = vy_s3[RW-1] ? -((-vy_s3) >>> 16) : (vy_s3 >>> 16);
	assign fl_last = fl_s[L-1];

	always_comb begin
		if (fl_last[0]) begin
			rowv = $signed({4'b0, crow});
			colv = $signed({4'b0, ccol});
		end else begin
			rowv = $signed({4'b0, crow}) - $signed(ty[15:0]);
			colv = $signed({4'b0, ccol}) + $signed(tx[15:0]);
		end
		if (rows_l == '0 || rowv < 0) row_c = '0;
		else if (rowv >= $signed({3'b0, rows_l})) row_c = 12'(rows_l - 13'd1);
		else row_c = rowv[11:0];
		if (cols_l == '0 || colv < 0) col_c = '0;
		else if (colv >= $signed({3'b0, cols_l})) col_c = 12'(cols_l - 13'd1);
		else col_c = colv[11:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= vs_q[L-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			use_background <= fl_last[1];
			pixel_row      <= fl_last[1] ? 12'd0 : row_c;
			pixel_col      <= fl_last[1] ? 12'd0 : col_c;
			color_out      <= fl_last[1] ? background_rgb : 24'd0;
		end
	end

endmodule

// ===== rtl/sky_direction_to_fisheye_pixel.sv =====
// Top level of the equidistant fisheye sky lookup: ray direction in, sky pixel or background out.
// Takes one ray direction request per clock while in_stall is low, and returns one result per
// request, in order. A request first passes a combinational front end that flags background
// cases (no texture, or z below the horizon) and the zenith case (x = y = 0), and pre-rotates
// (x, y) into the right half plane; it then waits in a four-entry queue. The back end is a single
// pipeline: azimuth vectoring CORDIC, zenith vectoring CORDIC, two multiply stages that turn the
// zenith angle into a radius, a rotation CORDIC that splits the radius into column and row
// offsets, a gain multiply and the clamp into the image. Each of the three CORDIC chains has one
// stage per micro-rotation. The back end freezes as a whole while a result waits on out_stall;
// the queue keeps accepting meanwhile until it is full, then in_stall rises.
// Configuration registers are read live by the pipeline, so write them only while idle.
module sky_direction_to_fisheye_pixel #(
	parameter int MAX_IMAGE_SIDE = 4096,
	parameter int DIR_BITS       = 16,
	parameter int CORDIC_STEPS   = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [23:0]                cfg_wdata,
	// request channel
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [DIR_BITS-1:0] dir_x,
	input  logic signed [DIR_BITS-1:0] dir_y,
	input  logic signed [DIR_BITS-1:0] dir_z,
	// result channel
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       use_background,
	output logic [11:0]                pixel_row,
	output logic [11:0]                pixel_col,
	output logic [23:0]                color_out
);

	// Configuration registers
	logic        texture_present_q;
	logic [12:0] image_rows_q;
	logic [12:0] image_cols_q;
	logic [23:0] background_rgb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			texture_present_q <= 1'b0;
			image_rows_q      <= '0;
			image_cols_q      <= '0;
			background_rgb_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				skyfe_pkg::REG_TEXTURE:    texture_present_q <= cfg_wdata[0];
				skyfe_pkg::REG_ROWS:       image_rows_q      <= cfg_wdata[12:0];
				skyfe_pkg::REG_COLS:       image_cols_q      <= cfg_wdata[12:0];
				skyfe_pkg::REG_BACKGROUND: background_rgb_q  <= cfg_wdata;
				default:                   ;
			endcase
		end
	end

	// Front end: classify and pre-rotate
	skyfe_pkg::item_t front_item;
	logic             push;

	skyfe_front #(
		.DIR_BITS(DIR_BITS)
	) u_front (
		.dir_x          (dir_x),
		.dir_y          (dir_y),
		.dir_z          (dir_z),
		.texture_present(texture_present_q),
		.item           (front_item)
	);

	// Queue between front and back
	logic             q_full, q_pop, q_valid;
	skyfe_pkg::item_t q_item;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	skyfe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.full      (q_full),
		.pop       (q_pop),
		.head_valid(q_valid),
		.head_item (q_item)
	);

	// Back end: CORDIC pipeline and output register
	skyfe_back #(
		.CORDIC_STEPS  (CORDIC_STEPS),
		.MAX_IMAGE_SIDE(MAX_IMAGE_SIDE)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (q_valid),
		.head_item     (q_item),
		.pop           (q_pop),
		.image_rows    (image_rows_q),
		.image_cols    (image_cols_q),
		.background_rgb(background_rgb_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.use_background(use_background),
		.pixel_row     (pixel_row),
		.pixel_col     (pixel_col),
		.color_out     (color_out)
	);

endmodule

// ===== rtl/skyfe_checker.sv =====
// Port-level checks on the result channel of the fisheye sky lookup, bound to the top level.
module skyfe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        use_background,
	input logic [11:0] pixel_row,
	input logic [11:0] pixel_col,
	input logic [23:0] color_out
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(pixel_row) && $stable(pixel_col)
			&& $stable(color_out) && $stable(use_background))
		else $error("stalled result changed");

	a_bg_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && use_background |-> pixel_row == 12'd0 && pixel_col == 12'd0)
		else $error("background result carries an address");

	a_px_color: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !use_background |-> color_out == 24'd0)
		else $error("pixel result carries a color");

endmodule

bind sky_direction_to_fisheye_pixel skyfe_checker u_skyfe_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.use_background(use_background),
	.pixel_row     (pixel_row),
	.pixel_col     (pixel_col),
	.color_out     (color_out)
);
